// ----- hdl/arf_pkg.sv -----
// Package for the AES round unit: S-box tables and GF(2^8) helpers.
// Used by the column lane and the top level; depends on nothing.
package arf_pkg;

  localparam int unsigned NumCols = 4;

  typedef logic [7:0] byte_t;
  typedef logic [31:0] col_t;

  function automatic byte_t fwd_sbox(input byte_t x);
    byte_t tbl [256];
    tbl = '{
      8'd99,8'd124,8'd119,8'd123,8'd242,8'd107,8'd111,8'd197,8'd48,8'd1,8'd103,8'd43,
      8'd254,8'd215,8'd171,8'd118,8'd202,8'd130,8'd201,8'd125,8'd250,8'd89,8'd71,8'd240,
      8'd173,8'd212,8'd162,8'd175,8'd156,8'd164,8'd114,8'd192,8'd183,8'd253,8'd147,8'd38,
      8'd54,8'd63,8'd247,8'd204,8'd52,8'd165,8'd229,8'd241,8'd113,8'd216,8'd49,8'd21,
      8'd4,8'd199,8'd35,8'd195,8'd24,8'd150,8'd5,8'd154,8'd7,8'd18,8'd128,8'd226,
      8'd235,8'd39,8'd178,8'd117,8'd9,8'd131,8'd44,8'd26,8'd27,8'd110,8'd90,8'd160,
      8'd82,8'd59,8'd214,8'd179,8'd41,8'd227,8'd47,8'd132,8'd83,8'd209,8'd0,8'd237,
      8'd32,8'd252,8'd177,8'd91,8'd106,8'd203,8'd190,8'd57,8'd74,8'd76,8'd88,8'd207,
      8'd208,8'd239,8'd170,8'd251,8'd67,8'd77,8'd51,8'd133,8'd69,8'd249,8'd2,8'd127,
      8'd80,8'd60,8'd159,8'd168,8'd81,8'd163,8'd64,8'd143,8'd146,8'd157,8'd56,8'd245,
      8'd188,8'd182,8'd218,8'd33,8'd16,8'd255,8'd243,8'd210,8'd205,8'd12,8'd19,8'd236,
      8'd95,8'd151,8'd68,8'd23,8'd196,8'd167,8'd126,8'd61,8'd100,8'd93,8'd25,8'd115,
      8'd96,8'd129,8'd79,8'd220,8'd34,8'd42,8'd144,8'd136,8'd70,8'd238,8'd184,8'd20,
      8'd222,8'd94,8'd11,8'd219,8'd224,8'd50,8'd58,8'd10,8'd73,8'd6,8'd36,8'd92,
      8'd194,8'd211,8'd172,8'd98,8'd145,8'd149,8'd228,8'd121,8'd231,8'd200,8'd55,8'd109,
      8'd141,8'd213,8'd78,8'd169,8'd108,8'd86,8'd244,8'd234,8'd101,8'd122,8'd174,8'd8,
      8'd186,8'd120,8'd37,8'd46,8'd28,8'd166,8'd180,8'd198,8'd232,8'd221,8'd116,8'd31,
      8'd75,8'd189,8'd139,8'd138,8'd112,8'd62,8'd181,8'd102,8'd72,8'd3,8'd246,8'd14,
      8'd97,8'd53,8'd87,8'd185,8'd134,8'd193,8'd29,8'd158,8'd225,8'd248,8'd152,8'd17,
      8'd105,8'd217,8'd142,8'd148,8'd155,8'd30,8'd135,8'd233,8'd206,8'd85,8'd40,8'd223,
      8'd140,8'd161,8'd137,8'd13,8'd191,8'd230,8'd66,8'd104,8'd65,8'd153,8'd45,8'd15,
      8'd176,8'd84,8'd187,8'd22};
    return tbl[x];
  endfunction

  function automatic byte_t inv_sbox(input byte_t x);
    byte_t tbl [256];
    tbl = '{
      8'd82,8'd9,8'd106,8'd213,8'd48,8'd54,8'd165,8'd56,8'd191,8'd64,8'd163,8'd158,
      8'd129,8'd243,8'd215,8'd251,8'd124,8'd227,8'd57,8'd130,8'd155,8'd47,8'd255,8'd135,
      8'd52,8'd142,8'd67,8'd68,8'd196,8'd222,8'd233,8'd203,8'd84,8'd123,8'd148,8'd50,
      8'd166,8'd194,8'd35,8'd61,8'd238,8'd76,8'd149,8'd11,8'd66,8'd250,8'd195,8'd78,
      8'd8,8'd46,8'd161,8'd102,8'd40,8'd217,8'd36,8'd178,8'd118,8'd91,8'd162,8'd73,
      8'd109,8'd139,8'd209,8'd37,8'd114,8'd248,8'd246,8'd100,8'd134,8'd104,8'd152,8'd22,
      8'd212,8'd164,8'd92,8'd204,8'd93,8'd101,8'd182,8'd146,8'd108,8'd112,8'd72,8'd80,
      8'd253,8'd237,8'd185,8'd218,8'd94,8'd21,8'd70,8'd87,8'd167,8'd141,8'd157,8'd132,
      8'd144,8'd216,8'd171,8'd0,8'd140,8'd188,8'd211,8'd10,8'd247,8'd228,8'd88,8'd5,
      8'd184,8'd179,8'd69,8'd6,8'd208,8'd44,8'd30,8'd143,8'd202,8'd63,8'd15,8'd2,
      8'd193,8'd175,8'd189,8'd3,8'd1,8'd19,8'd138,8'd107,8'd58,8'd145,8'd17,8'd65,
      8'd79,8'd103,8'd220,8'd234,8'd151,8'd242,8'd207,8'd206,8'd240,8'd180,8'd230,8'd115,
      8'd150,8'd172,8'd116,8'd34,8'd231,8'd173,8'd53,8'd133,8'd226,8'd249,8'd55,8'd232,
      8'd28,8'd117,8'd223,8'd110,8'd71,8'd241,8'd26,8'd113,8'd29,8'd41,8'd197,8'd137,
      8'd111,8'd183,8'd98,8'd14,8'd170,8'd24,8'd190,8'd27,8'd252,8'd86,8'd62,8'd75,
      8'd198,8'd210,8'd121,8'd32,8'd154,8'd219,8'd192,8'd254,8'd120,8'd205,8'd90,8'd244,
      8'd31,8'd221,8'd168,8'd51,8'd136,8'd7,8'd199,8'd49,8'd177,8'd18,8'd16,8'd89,
      8'd39,8'd128,8'd236,8'd95,8'd96,8'd81,8'd127,8'd169,8'd25,8'd181,8'd74,8'd13,
      8'd45,8'd229,8'd122,8'd159,8'd147,8'd201,8'd156,8'd239,8'd160,8'd224,8'd59,8'd77,
      8'd174,8'd42,8'd245,8'd176,8'd200,8'd235,8'd187,8'd60,8'd131,8'd83,8'd153,8'd97,
      8'd23,8'd43,8'd4,8'd126,8'd186,8'd119,8'd214,8'd38,8'd225,8'd105,8'd20,8'd99,
      8'd85,8'd33,8'd12,8'd125};
    return tbl[x];
  endfunction

  function automatic byte_t gf_dbl(input byte_t x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

// ----- hdl/arf_col_lane.sv -----
// One column lane: SubBytes, MixColumns and AddRoundKey forward, AddRoundKey and InvMixColumns inverse.
// Depends on arf_pkg. Purely combinational; the top level registers the result.
module arf_col_lane (
  input  arf_pkg::col_t fwd_col_i,
  input  arf_pkg::col_t inv_col_i,
  input  arf_pkg::col_t key_i,
  output arf_pkg::col_t fwd_mix_o,
  output arf_pkg::col_t inv_mix_o
);
  import arf_pkg::*;

  byte_t sb [4];
  byte_t ib [4];
  byte_t x2 [4];
  byte_t y2 [4];
  byte_t y4 [4];
  byte_t y8 [4];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sb[r] = fwd_sbox(fwd_col_i[31-8*r -: 8]);
      ib[r] = inv_col_i[31-8*r -: 8] ^ key_i[31-8*r -: 8];
      x2[r] = gf_dbl(sb[r]);
      y2[r] = gf_dbl(ib[r]);
      y4[r] = gf_dbl(y2[r]);
      y8[r] = gf_dbl(y4[r]);
    end
    for (int r = 0; r < 4; r++) begin
      fwd_mix_o[31-8*r -: 8] = x2[r] ^ x2[(r+1)%4] ^ sb[(r+1)%4] ^ sb[(r+2)%4]
                               ^ sb[(r+3)%4] ^ key_i[31-8*r -: 8];
      inv_mix_o[31-8*r -: 8] = (y8[r] ^ y4[r] ^ y2[r])
                               ^ (y8[(r+1)%4] ^ y2[(r+1)%4] ^ ib[(r+1)%4])
                               ^ (y8[(r+2)%4] ^ y4[(r+2)%4] ^ ib[(r+2)%4])
                               ^ (y8[(r+3)%4] ^ ib[(r+3)%4]);
    end
  end
endmodule

// ----- hdl/aes_round_forward_inverse.sv -----
// Top level of the AES round unit: four column lanes and a merging stage.
// The result is registered; throughput is one item a cycle while the output does not stall.
// A skid register holds a result when the output stalls, so input ready drops only then.
// Reset (rst_ni, asynchronous, active low) clears the valid flags; the data registers are not reset.
// Depends on arf_pkg and arf_col_lane.
module aes_round_forward_inverse (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic        mode_i,
  input  logic [63:0] state_hi_i,
  input  logic [63:0] state_lo_i,
  input  logic [63:0] round_key_hi_i,
  input  logic [63:0] round_key_lo_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [63:0] result_hi_o,
  output logic [63:0] result_lo_o
);
  import arf_pkg::*;

  logic [127:0] st, ky, res;
  byte_t sb [16];
  byte_t kb [16];
  col_t fcol [4], icol [4], kcol [4], fmix [4], imix [4];
  byte_t fb [16], ibb [16];

  assign st = {state_hi_i, state_lo_i};
  assign ky = {round_key_hi_i, round_key_lo_i};

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      sb[k] = st[127-8*k -: 8];
      kb[k] = ky[127-8*k -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      fcol[c] = {sb[4*((c)%4)+0], sb[4*((c+1)%4)+1], sb[4*((c+2)%4)+2], sb[4*((c+3)%4)+3]};
      icol[c] = {sb[4*c], sb[4*c+1], sb[4*c+2], sb[4*c+3]};
      kcol[c] = {kb[4*c], kb[4*c+1], kb[4*c+2], kb[4*c+3]};
    end
  end

  for (genvar g = 0; g < NumCols; g++) begin : g_lane
    arf_col_lane u_lane (
      .fwd_col_i (fcol[g]),
      .inv_col_i (icol[g]),
      .key_i     (kcol[g]),
      .fwd_mix_o (fmix[g]),
      .inv_mix_o (imix[g])
    );
  end

  // Merging stage: inverse shift rows and inverse S-box across lanes, then mode_i selects inverse or forward bytes.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        fb[4*c+r]  = fmix[c][31-8*r -: 8];
        ibb[4*c+r] = inv_sbox(imix[(c+4-r)%4][31-8*r -: 8]);
      end
    end
    for (int k = 0; k < 16; k++) begin
      res[127-8*k -: 8] = mode_i ? ibb[k] : fb[k];
    end
  end

  logic         out_vld_q, skid_vld_q;
  logic [127:0] out_q, skid_q;

  assign ready_o = !skid_vld_q;
  assign valid_o = out_vld_q;
  assign result_hi_o = out_q[127:64];
  assign result_lo_o = out_q[63:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (!out_vld_q || ready_i) begin
        out_vld_q  <= skid_vld_q || valid_i;
        skid_vld_q <= 1'b0;
      end else if (valid_i && ready_o) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || ready_i) begin
      out_q <= skid_vld_q ? skid_q : res;
    end else if (valid_i && ready_o) begin
      skid_q <= res;
    end
  end

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q) else $error("skid full while output empty");
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !ready_i) |=> (valid_o && $stable(out_q))) else $error("result lost");
  a_accept_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && ready_o) |=> valid_o) else $error("accepted item missing");
`endif
endmodule
